// ----- rtl/xkb_pkg.sv -----
// Shared types, constants and character mapping functions for the
// repeating-key XOR / base64 codec. No dependencies.
package xkb_pkg;

    // Default number of key bytes held in the key store
    localparam int KEY_BYTES_DEF = 16;

    // Register map of the configuration port
    typedef enum logic [1:0] {
        CFG_DIRECTION  = 2'd0,
        CFG_KEY_LENGTH = 2'd1,
        CFG_KEY_LOW    = 2'd2,
        CFG_KEY_HIGH   = 2'd3
    } t_cfg_index;

    // Direction register values
    localparam logic DIR_ENCODE = 1'b0;

    localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='
    localparam int         RES_SLOTS = 4;     // most results caused by one item

    // One result transaction
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       end_of_message;
        logic       error;
    } t_result;

    // Status of the result buffer, seen by the top level
    typedef struct packed {
        logic [2:0] count;    // results still waiting
        logic       load_ok;  // a new set of results may be written this cycle
    } t_buf_status;

    // 6-bit value to base64 character
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        c = 8'h2F;  // '/'
        if (v < 6'd26)       c = 8'h41 + 8'(v);
        else if (v < 6'd52)  c = 8'h61 + 8'(v - 6'd26);
        else if (v < 6'd62)  c = 8'h30 + 8'(v - 6'd52);
        else if (v == 6'd62) c = 8'h2B;
        return c;
    endfunction

    // Base64 character to 6-bit value; bit 6 set means not in the alphabet
    function automatic logic [6:0] b64_value(input logic [7:0] c);
        logic [6:0] v;
        case (c) inside
            [8'h41:8'h5A]: v = 7'(c - 8'h41);
            [8'h61:8'h7A]: v = 7'(c - 8'h61) + 7'd26;
            [8'h30:8'h39]: v = 7'(c - 8'h30) + 7'd52;
            8'h2B:         v = 7'd62;
            8'h2F:         v = 7'd63;
            default:       v = 7'd64;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/xkb_key_gen.sv -----
// Key store and key stream generator: holds key bytes and key length,
// gives the next three key bytes and positions. Depends on xkb_pkg.
module xkb_key_gen #(
    parameter int KEY_BYTES = xkb_pkg::KEY_BYTES_DEF,
    parameter int KP_W      = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic [1:0]      i_cfg_index,
    input  logic [63:0]     i_cfg_data,
    input  logic [KP_W-1:0] i_pos,
    output logic [7:0]      o_kb       [3],
    output logic [KP_W-1:0] o_pos_next [3]
);

    logic [7:0] r_key [KEY_BYTES];
    logic [4:0] r_key_len;
    logic [4:0] len_eff;
    logic [4:0] p    [3];
    logic [4:0] pnx  [3];

    // Key length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_len <= '0;
        end else if (i_cfg_wr_en && i_cfg_index == xkb_pkg::CFG_KEY_LENGTH) begin
            r_key_len <= i_cfg_data[4:0];
        end
    end

    // Key bytes; only entries below KEY_BYTES are stored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < KEY_BYTES; i++) r_key[i] <= '0;
        end else if (i_cfg_wr_en) begin
            for (int i = 0; i < KEY_BYTES; i++) begin
                if (i < 8 && i_cfg_index == xkb_pkg::CFG_KEY_LOW)
                    r_key[i] <= i_cfg_data[(i % 8) * 8 +: 8];
                if (i >= 8 && i_cfg_index == xkb_pkg::CFG_KEY_HIGH)
                    r_key[i] <= i_cfg_data[(i % 8) * 8 +: 8];
            end
        end
    end

    assign len_eff = (r_key_len > 5'(KEY_BYTES)) ? 5'(KEY_BYTES) : r_key_len;

    // Three consecutive key positions, each wrapping at the key length.
    // A stale position at or past the length restarts at byte 0.
    always_comb begin
        p[0] = (5'(i_pos) < len_eff) ? 5'(i_pos) : 5'd0;
        for (int k = 0; k < 3; k++) begin
            pnx[k] = (p[k] + 5'd1 >= len_eff) ? 5'd0 : p[k] + 5'd1;
            if (k < 2) p[k + 1] = pnx[k];
        end
        for (int k = 0; k < 3; k++) begin
            if (len_eff == 5'd0) begin
                o_kb[k]       = 8'h00;
                o_pos_next[k] = i_pos;
            end else begin
                o_kb[k]       = r_key[p[k][KP_W-1:0]];
                o_pos_next[k] = pnx[k][KP_W-1:0];
            end
        end
    end

endmodule

// ----- rtl/xkb_core.sv -----
// Codec datapath: group state registers and the single-pass encode/decode
// logic that turns one item into up to four results. Depends on xkb_pkg.
module xkb_core #(
    parameter int KP_W = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    input  logic                 i_dir,
    input  logic [7:0]           i_kb       [3],
    input  logic [KP_W-1:0]      i_pos_next [3],
    output logic [KP_W-1:0]      o_pos,
    output xkb_pkg::t_result     o_res      [xkb_pkg::RES_SLOTS],
    output logic [2:0]           o_count
);

    logic [17:0]     r_gb, n_gb;
    logic [1:0]      r_gc, n_gc;
    logic [KP_W-1:0] r_pos, n_pos;
    logic            r_pad, n_pad;
    logic            r_err, n_err;

    logic [7:0]  b;
    logic [23:0] val;
    logic [2:0]  nch;
    logic [6:0]  v;
    logic        tail;
    logic [17:0] tgb;
    logic [1:0]  tgc;
    logic [2:0]  cnt;

    // Group state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gb  <= '0;
            r_gc  <= '0;
            r_pos <= '0;
            r_pad <= 1'b0;
            r_err <= 1'b0;
        end else if (i_fire) begin
            r_gb  <= n_gb;
            r_gc  <= n_gc;
            r_pos <= n_pos;
            r_pad <= n_pad;
            r_err <= n_err;
        end
    end

    assign o_pos = r_pos;

    always_comb begin
        n_gb  = r_gb;
        n_gc  = r_gc;
        n_pos = r_pos;
        n_pad = r_pad;
        n_err = r_err;
        b     = i_byte ^ i_kb[0];
        val   = '0;
        nch   = 3'd0;
        v     = xkb_pkg::b64_value(i_byte);
        tail  = 1'b0;
        tgb   = r_gb;
        tgc   = r_gc;
        cnt   = 3'd0;
        for (int k = 0; k < xkb_pkg::RES_SLOTS; k++) o_res[k] = '0;

        if (i_dir == xkb_pkg::DIR_ENCODE) begin
            // XOR, then collect three bytes into four characters
            n_pos = i_pos_next[0];
            if (r_gc >= 2'd2) begin
                val  = {r_gb[15:0], b};
                nch  = 3'd4;
                n_gb = '0;
                n_gc = '0;
            end else if (i_last) begin
                if (r_gc == 2'd1) begin
                    val = {r_gb[7:0], b, 8'h00};
                    nch = 3'd3;
                end else begin
                    val = {b, 16'h0000};
                    nch = 3'd2;
                end
            end else begin
                n_gb = {r_gb[9:0], b};
                n_gc = r_gc + 2'd1;
            end
            if (nch != 3'd0) begin
                cnt = 3'd4;
                for (int k = 0; k < 4; k++) begin
                    o_res[k].is_data  = 1'b1;
                    o_res[k].out_byte = (3'(k) < nch) ?
                        xkb_pkg::b64_char(val[(23 - 6 * k) -: 6]) : xkb_pkg::PAD_CHAR;
                end
            end
        end else begin
            // Decode: after an error no more data bytes are produced
            if (r_err) begin
                tail = 1'b0;
            end else if (i_byte == xkb_pkg::PAD_CHAR) begin
                n_pad = 1'b1;
                tail  = 1'b1;
            end else if (r_pad || v[6]) begin
                n_err = 1'b1;
            end else if (r_gc == 2'd3) begin
                val   = {r_gb, v[5:0]};
                n_gb  = '0;
                n_gc  = '0;
                n_pos = i_pos_next[2];
                cnt   = 3'd3;
                for (int k = 0; k < 3; k++) begin
                    o_res[k].is_data  = 1'b1;
                    o_res[k].out_byte = val[(23 - 8 * k) -: 8] ^ i_kb[k];
                end
            end else begin
                n_gb = {r_gb[11:0], v[5:0]};
                n_gc = r_gc + 2'd1;
                tgb  = n_gb;
                tgc  = n_gc;
                tail = 1'b1;
            end

            // Flush of a partial group on the final character
            if (tail && i_last) begin
                if (tgc == 2'd2) begin
                    o_res[0].is_data  = 1'b1;
                    o_res[0].out_byte = tgb[11:4] ^ i_kb[0];
                    n_pos = i_pos_next[0];
                    cnt   = 3'd1;
                end else if (tgc == 2'd3) begin
                    o_res[0].is_data  = 1'b1;
                    o_res[0].out_byte = tgb[17:10] ^ i_kb[0];
                    o_res[1].is_data  = 1'b1;
                    o_res[1].out_byte = tgb[9:2] ^ i_kb[1];
                    n_pos = i_pos_next[1];
                    cnt   = 3'd2;
                end
            end
        end

        // End of message: bare marker if nothing else, flags on the final result
        if (i_last) begin
            if (cnt == 3'd0) cnt = 3'd1;
            for (int k = 0; k < xkb_pkg::RES_SLOTS; k++) begin
                if (3'(k) == cnt - 3'd1) begin
                    o_res[k].end_of_message = 1'b1;
                    o_res[k].error          = n_err;
                end
            end
            n_gb  = '0;
            n_gc  = '0;
            n_pos = '0;
            n_pad = 1'b0;
            n_err = 1'b0;
        end
        o_count = cnt;
    end

endmodule

// ----- rtl/xkb_out_buf.sv -----
// Result buffer: takes up to four results at once and hands them to the
// output stream one per cycle while i_ready holds. Depends on xkb_pkg.
module xkb_out_buf (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  xkb_pkg::t_result      i_res [xkb_pkg::RES_SLOTS],
    input  logic [2:0]            i_count,
    output logic                  o_valid,
    input  logic                  i_ready,
    output xkb_pkg::t_result      o_res,
    output xkb_pkg::t_buf_status  o_status
);

    xkb_pkg::t_result r_buf [xkb_pkg::RES_SLOTS];
    logic [2:0] r_cnt;
    logic [1:0] r_rd;
    logic       fire;

    assign o_valid = (r_cnt != 3'd0);
    assign fire    = o_valid && i_ready;
    assign o_res   = r_buf[r_rd];

    assign o_status.count   = r_cnt;
    assign o_status.load_ok = (r_cnt == 3'd0) || (r_cnt == 3'd1 && fire);

    // Fill level and read pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= '0;
        end else if (i_load) begin
            r_cnt <= i_count;
            r_rd  <= '0;
        end else if (fire) begin
            r_cnt <= r_cnt - 3'd1;
            r_rd  <= r_rd + 2'd1;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int k = 0; k < xkb_pkg::RES_SLOTS; k++) r_buf[k] <= i_res[k];
        end
    end

endmodule

// ----- rtl/xor_key_base64_codec.sv -----
// Top level of the repeating-key XOR / base64 codec: input register,
// direction register, key generator, codec core and result buffer.
// Depends on xkb_pkg, xkb_key_gen, xkb_core, xkb_out_buf.
//
// Usage:
//  - s_axis: one transaction per item; tdata is the raw byte (encode) or a
//    base64 character (decode), tlast marks the final item of a message.
//  - m_axis: one transaction per result; tdata is the character or decoded
//    byte, tlast is end_of_message, tuser carries is_data and error.
//  - Configuration: write direction, key length and key words through the
//    write port only while no message item is in flight.
//  - An accepted item waits in the input register until the result buffer can
//    take its results, and is then processed in one pass into that buffer.
//  - Throughput: items that cause no result go through at one per cycle;
//    a set of n results drains at one per cycle from the four-entry result
//    buffer while the receiver is ready, so decoding runs one character per
//    cycle and encoding is limited by the single output port of the buffer.
//  - A stalled receiver holds the buffer; the input register then holds
//    one item and tready drops until the buffer can take its results.
//  - Synchronous reset clears the message state, the key and the buffer.
module xor_key_base64_codec #(
    parameter int KEY_BYTES = xkb_pkg::KEY_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,
    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,
    output logic [1:0]  m_axis_tuser    // [0] is_data, [1] error
);

    localparam int KP_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

    logic            r_in_valid;
    logic [7:0]      r_in_byte;
    logic            r_in_last;
    logic            r_dir;
    logic            w_proc;
    logic            w_load;
    logic [7:0]      w_kb       [3];
    logic [KP_W-1:0] w_pos_next [3];
    logic [KP_W-1:0] w_pos;
    logic [2:0]      w_count;
    xkb_pkg::t_result     w_res [xkb_pkg::RES_SLOTS];
    xkb_pkg::t_result     w_out;
    xkb_pkg::t_buf_status w_status;

    // Process the held item when its results fit, or when it has none
    assign w_proc        = r_in_valid && (w_status.load_ok || w_count == 3'd0);
    assign w_load        = w_proc && (w_count != 3'd0);
    assign s_axis_tready = !r_in_valid || w_proc;

    // Input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // Input register payload
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // Direction register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= xkb_pkg::DIR_ENCODE;
        end else if (i_cfg_wr_en && i_cfg_index == xkb_pkg::CFG_DIRECTION) begin
            r_dir <= i_cfg_data[0];
        end
    end

    xkb_key_gen #(
        .KEY_BYTES (KEY_BYTES),
        .KP_W      (KP_W)
    ) u_key_gen (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pos       (w_pos),
        .o_kb        (w_kb),
        .o_pos_next  (w_pos_next)
    );

    xkb_core #(
        .KP_W (KP_W)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_proc),
        .i_byte     (r_in_byte),
        .i_last     (r_in_last),
        .i_dir      (r_dir),
        .i_kb       (w_kb),
        .i_pos_next (w_pos_next),
        .o_pos      (w_pos),
        .o_res      (w_res),
        .o_count    (w_count)
    );

    xkb_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_res    (w_res),
        .i_count  (w_count),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_res    (w_out),
        .o_status (w_status)
    );

    assign m_axis_tdata    = w_out.out_byte;
    assign m_axis_tlast    = w_out.end_of_message;
    assign m_axis_tuser[0] = w_out.is_data;
    assign m_axis_tuser[1] = w_out.error;

    // Buffer never holds more than one item's results
    a_buf_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.count <= 3'd4)
        else $error("result buffer count out of range");

    // Results are written only into an empty or emptying buffer
    a_load_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (w_status.count == 3'd0 ||
                    (w_status.count == 3'd1 && m_axis_tvalid && m_axis_tready)))
        else $error("result buffer overwritten");

    // End of message is always the last result held
    a_eom_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> w_status.count == 3'd1)
        else $error("end of message not the final buffered result");

    // Output idle right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

// ----- tb/testbench.sv -----
// Testbench for xor_key_base64_codec: a stream driver and a monitor with random
// idling, checked against an in-bench model of the key XOR and base64 codec.
// Depends on xkb_pkg and the codec RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic DIR_DECODE    = ~xkb_pkg::DIR_ENCODE;
    localparam int   KEY_MAX       = xkb_pkg::KEY_BYTES_DEF;
    localparam int   SETTLE_CYCLES = 8;
    localparam int   HOLD_CYCLES   = 300;
    localparam int   PHASE_ITEMS   = 45;
    localparam int   RUN_LIMIT_NS  = 2_000_000;

    // One input transaction waiting to be offered
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_item;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [1:0]  i_cfg_index   = '0;
    logic [63:0] i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // [7:0] in_byte
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // [7:0] out_byte
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;         // [0] is_data, [1] error

    xor_key_base64_codec #(.KEY_BYTES(KEY_MAX)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock and run limit
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("xor_key_base64_codec: mismatch");
        $finish;
    end

    // Shadow copy of the registers and of the message state
    logic        cfg_dir     = xkb_pkg::DIR_ENCODE;
    logic [4:0]  cfg_key_len = '0;
    logic [63:0] cfg_key_lo  = '0;
    logic [63:0] cfg_key_hi  = '0;
    logic [17:0] grp_bits    = '0;
    logic [1:0]  grp_cnt     = '0;
    logic [3:0]  key_pos     = '0;
    logic        pad_flag    = 1'b0;
    logic        err_flag    = 1'b0;

    string   b64_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    t_item   pend_items[$];
    xkb_pkg::t_result step_out[$];
    xkb_pkg::t_result codec_out_q[$];

    int n_queued    = 0;
    int n_accepted  = 0;
    int n_errors    = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_asks   = 0;
    int hold_served = 0;
    int hold_left   = 0;

    // Next byte of the repeating key; length saturates, stale position wraps to 0
    function automatic logic [7:0] next_key();
        int         len;
        int         pos;
        logic [7:0] kb;
        len = (int'(cfg_key_len) > KEY_MAX) ? KEY_MAX : int'(cfg_key_len);
        if (len == 0)
            return 8'h00;
        pos = (int'(key_pos) < len) ? int'(key_pos) : 0;
        kb  = (pos < 8) ? cfg_key_lo[8*pos +: 8] : cfg_key_hi[8*(pos-8) +: 8];
        pos++;
        if (pos >= len)
            pos = 0;
        key_pos = 4'(pos);
        return kb;
    endfunction

    // Position in the alphabet, 64 when the character is not in it
    function automatic int b64_index(input logic [7:0] c);
        for (int i = 0; i < 64; i++)
            if (8'(b64_set[i]) == c)
                return i;
        return 64;
    endfunction

    function automatic void push_data(input logic [7:0] b);
        xkb_pkg::t_result r;
        r.out_byte       = b;
        r.is_data        = 1'b1;
        r.end_of_message = 1'b0;
        r.error          = 1'b0;
        step_out.push_back(r);
    endfunction

    // Four characters from a 24-bit group, the tail filled with '='
    function automatic void emit_chars(input logic [23:0] w, input int nch);
        for (int k = 0; k < 4; k++)
            if (k < nch)
                push_data(8'(b64_set[w[23-6*k -: 6]]));
            else
                push_data(xkb_pkg::PAD_CHAR);
    endfunction

    // Expected results of one accepted input transaction
    function automatic void codec_step(input logic [7:0] b, input logic last);
        logic [7:0]       x;
        logic [23:0]      w;
        int               v;
        bit               flush;
        xkb_pkg::t_result r;
        flush = 1'b0;
        if (cfg_dir == xkb_pkg::DIR_ENCODE) begin
            x = b ^ next_key();
            if (grp_cnt >= 2'd2) begin
                // a held count of 3 also completes the group here
                w = {grp_bits[15:0], x};
                grp_bits = '0;
                grp_cnt  = '0;
                emit_chars(w, 4);
            end else if (last) begin
                if (grp_cnt == 2'd1)
                    emit_chars({grp_bits[7:0], x, 8'h00}, 3);
                else
                    emit_chars({x, 16'h0000}, 2);
            end else begin
                grp_bits = {grp_bits[9:0], x};
                grp_cnt++;
            end
        end else if (!err_flag) begin
            if (b == xkb_pkg::PAD_CHAR) begin
                pad_flag = 1'b1;
                flush    = 1'b1;
            end else begin
                v = b64_index(b);
                if (pad_flag || v > 63) begin
                    err_flag = 1'b1;
                end else if (grp_cnt == 2'd3) begin
                    w = {grp_bits, 6'(v)};
                    push_data(w[23:16] ^ next_key());
                    push_data(w[15:8] ^ next_key());
                    push_data(w[7:0] ^ next_key());
                    grp_bits = '0;
                    grp_cnt  = '0;
                end else begin
                    grp_bits = {grp_bits[11:0], 6'(v)};
                    grp_cnt++;
                    flush = 1'b1;
                end
            end
            // tail of the message: 2 chars give one byte, 3 give two
            if (flush && last) begin
                if (grp_cnt == 2'd2) begin
                    push_data(grp_bits[11:4] ^ next_key());
                end else if (grp_cnt == 2'd3) begin
                    push_data(grp_bits[17:10] ^ next_key());
                    push_data(grp_bits[9:2] ^ next_key());
                end
            end
        end

        if (last) begin
            if (step_out.size() == 0) begin
                r = '0;
                step_out.push_back(r);
            end
            r = step_out.pop_back();
            r.end_of_message = 1'b1;
            r.error          = err_flag;
            step_out.push_back(r);
            grp_bits = '0;
            grp_cnt  = '0;
            key_pos  = '0;
            pad_flag = 1'b0;
            err_flag = 1'b0;
        end
        while (step_out.size() != 0)
            codec_out_q.push_back(step_out.pop_front());
    endfunction

    // Driver: offers pending items, predicts on each accepted transaction
    always @(posedge i_clk) begin : drv
        t_item it;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                codec_step(s_axis_tdata, s_axis_tlast);
                n_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pend_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    it = pend_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= it.data;
                    s_axis_tlast  <= it.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (hold_served != hold_asks) begin
                hold_served = hold_asks;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Monitor: each result transaction against the oldest expectation
    // (fields shown as byte, is_data, end_of_message, error)
    always @(posedge i_clk) begin : mon
        xkb_pkg::t_result got;
        xkb_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]};
            if (codec_out_q.size() == 0) begin
                n_errors++;
                $display("%0t: expected none, got %h %b %b %b",
                         $time, got.out_byte, got.is_data, got.end_of_message,
                         got.error);
            end else begin
                want = codec_out_q.pop_front();
                if (got !== want) begin
                    n_errors++;
                    $display("%0t: expected %h %b %b %b, got %h %b %b %b",
                             $time, want.out_byte, want.is_data, want.end_of_message,
                             want.error, got.out_byte, got.is_data, got.end_of_message,
                             got.error);
                end
            end
        end
    end

    task automatic send(input logic [7:0] data, input logic last);
        t_item it;
        it.data = data;
        it.last = last;
        pend_items.push_back(it);
        n_queued++;
    endtask

    task automatic send_text(input string s, input bit last);
        for (int i = 0; i < s.len(); i++)
            send(8'(s[i]), last && (i == s.len() - 1));
    endtask

    // Wait for every item accepted and every result seen, then let the block settle
    task automatic wait_drained();
        do @(negedge i_clk);
        while (n_accepted != n_queued || codec_out_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input xkb_pkg::t_cfg_index idx, input logic [63:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            xkb_pkg::CFG_DIRECTION:  cfg_dir     = val[0];
            xkb_pkg::CFG_KEY_LENGTH: cfg_key_len = val[4:0];
            xkb_pkg::CFG_KEY_LOW:    cfg_key_lo  = val;
            xkb_pkg::CFG_KEY_HIGH:   cfg_key_hi  = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic random_config();
        logic [4:0] len;
        case ($urandom_range(0, 5))
            0:       len = 5'd0;
            1:       len = 5'd1;
            2:       len = 5'(KEY_MAX);
            3:       len = 5'($urandom_range(17, 31));
            default: len = 5'($urandom_range(2, 15));
        endcase
        wait_drained();
        cfg_write(xkb_pkg::CFG_DIRECTION, 64'($urandom_range(0, 1)));
        cfg_write(xkb_pkg::CFG_KEY_LENGTH, 64'(len));
        cfg_write(xkb_pkg::CFG_KEY_LOW, {$urandom, $urandom});
        cfg_write(xkb_pkg::CFG_KEY_HIGH, {$urandom, $urandom});
    endtask

    task automatic send_encode_msg();
        int nb;
        nb = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        for (int k = 0; k < nb; k++)
            send(8'($urandom_range(0, 255)), k == nb - 1);
    endtask

    // Mostly well-formed base64 of random bytes; some stripped, noisy, cut short or extended
    task automatic send_decode_msg();
        logic [7:0]  raw[$];
        logic [7:0]  chars[$];
        logic [23:0] w;
        int          nb;
        int          rem;
        int          mode;
        nb = $urandom_range(1, 9);
        for (int k = 0; k < nb; k++)
            raw.push_back(8'($urandom_range(0, 255)));
        raw.push_back(8'h00);
        raw.push_back(8'h00);
        for (int k = 0; k < nb; k += 3) begin
            rem = nb - k;
            w = {raw[k], raw[k+1], raw[k+2]};
            chars.push_back(8'(b64_set[w[23:18]]));
            chars.push_back(8'(b64_set[w[17:12]]));
            chars.push_back((rem > 1) ? 8'(b64_set[w[11:6]]) : xkb_pkg::PAD_CHAR);
            chars.push_back((rem > 2) ? 8'(b64_set[w[5:0]]) : xkb_pkg::PAD_CHAR);
        end
        mode = $urandom_range(0, 9);
        case (mode)
            0: while (chars[chars.size()-1] == xkb_pkg::PAD_CHAR)
                   void'(chars.pop_back());
            1: chars[$urandom_range(0, chars.size() - 1)] = 8'($urandom_range(0, 255));
            2: void'(chars.pop_back());
            3: chars.push_back(8'(b64_set[$urandom_range(0, 63)]));
            default: ;
        endcase
        for (int k = 0; k < chars.size(); k++)
            send(chars[k], k == chars.size() - 1);
    endtask

    // Stimulus: directed cases, then three random phases with different idling
    initial begin
        int start;
        tx_idle_pct = 21;
        rx_idle_pct = 68;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // encode without key: full group, then a one byte tail
        cfg_write(xkb_pkg::CFG_DIRECTION, 64'(xkb_pkg::DIR_ENCODE));
        cfg_write(xkb_pkg::CFG_KEY_LENGTH, 64'd0);
        cfg_write(xkb_pkg::CFG_KEY_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        cfg_write(xkb_pkg::CFG_KEY_HIGH, {$urandom, $urandom});
        send(8'h00, 1'b0);
        send(8'hFF, 1'b0);
        send(8'h80, 1'b0);
        send(8'h7F, 1'b1);
        wait_drained();
        // key length beyond the key store saturates
        cfg_write(xkb_pkg::CFG_KEY_LENGTH, 64'd31);
        send(8'hAA, 1'b0);
        send(8'h55, 1'b1);
        wait_drained();
        // key length shrinks below the position within a message
        cfg_write(xkb_pkg::CFG_KEY_LENGTH, 64'd6);
        for (int k = 0; k < 4; k++)
            send(8'($urandom_range(0, 255)), 1'b0);
        wait_drained();
        cfg_write(xkb_pkg::CFG_KEY_LENGTH, 64'd3);
        send(8'($urandom_range(0, 255)), 1'b1);
        wait_drained();

        // decode: group plus padded tail, unpadded tail, bad char, data after pad
        cfg_write(xkb_pkg::CFG_DIRECTION, 64'(DIR_DECODE));
        cfg_write(xkb_pkg::CFG_KEY_LENGTH, 64'd0);
        send_text("+/z09A=", 1'b1);
        send_text("QUI", 1'b1);
        send_text("*", 1'b1);
        send_text("=Q", 1'b1);
        // three chars held, then the direction flips to encode
        send_text("QUI", 1'b0);
        wait_drained();
        cfg_write(xkb_pkg::CFG_DIRECTION, 64'(xkb_pkg::DIR_ENCODE));
        send(8'h41, 1'b1);

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0:       begin tx_idle_pct = 21; rx_idle_pct = 68; end
                1:       begin tx_idle_pct = 68; rx_idle_pct = 21; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            start = n_queued;
            if (ph == 2) begin
                // receiver holds off while a long message keeps coming
                wait_drained();
                cfg_write(xkb_pkg::CFG_DIRECTION, 64'(xkb_pkg::DIR_ENCODE));
                hold_asks++;
                for (int k = 0; k < 24; k++)
                    send(8'($urandom_range(0, 255)), k == 23);
            end
            random_config();
            while (n_queued - start < PHASE_ITEMS) begin
                if ($urandom_range(0, 2) == 0)
                    random_config();
                if (cfg_dir == xkb_pkg::DIR_ENCODE)
                    send_encode_msg();
                else
                    send_decode_msg();
            end
        end

        wait_drained();
        if (n_errors == 0)
            $display("xor_key_base64_codec: match");
        else
            $display("xor_key_base64_codec: mismatch");
        $finish;
    end

endmodule
